// ===== design/soc_pkg.sv =====
package soc_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int MAX_ROM_BYTES = 4096;
  localparam int ADDR_W        = 13;
  localparam int ENTRY_W       = 12;

  localparam logic [ADDR_W-1:0]  LOAD_BASE = 13'h200;
  localparam logic [ADDR_W:0]    ROM_CAP   = 14'(MAX_ROM_BYTES);
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(TABLE_ENTRIES);

  // Instruction kinds.
  typedef enum logic [5:0] {
    K_SCD, K_CLS, K_RET, K_SCR, K_SCL, K_EXIT, K_LOW, K_HIGH,
    K_JP, K_CALL, K_SE_KK, K_SNE_KK, K_SE_XY, K_LD_KK, K_ADD_KK, K_LD_XY,
    K_OR, K_AND, K_XOR, K_ADD_XY, K_SUB, K_SHR, K_SUBN, K_SHL, K_SNE_XY,
    K_LD_I, K_JP_V0, K_RND, K_DRW, K_SKP, K_SKNP,
    K_LD_X_DT, K_LD_X_K, K_LD_DT_X, K_LD_ST_X, K_ADD_I_X,
    K_LD_LF, K_LD_HF, K_LD_B, K_LD_MEM_X, K_LD_X_MEM, K_LD_R_X, K_LD_X_R,
    K_DATA
  } kind_t;

  // Which table the target of the current word is looked up in.
  typedef enum logic [1:0] {TS_NONE, TS_FUNC, TS_LABEL, TS_DATA} tsel_t;

  typedef struct packed {
    logic                first_word;
    logic [15:0]         opcode_word;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   word_address;
    logic [15:0]         opcode_echo;
    logic [5:0]          instr_kind;
    logic                func_hit;
    logic [5:0]          func_number;
    logic                label_hit;
    logic [5:0]          label_number;
    logic [5:0]          target_number;
    logic                table_overflow;
  } out_item_t;

  // Query token travelling along the row of cells.
  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   here;
    logic [ENTRY_W-1:0]  nnn;
    tsel_t               tsel;
    logic                fhit;
    logic [IDX_W-1:0]    fidx;
    logic                lhit;
    logic [IDX_W-1:0]    lidx;
    logic                dhit;
    logic                thit;
    logic [IDX_W-1:0]    tidx;
  } token_t;

  // Fill levels of the three tables.
  typedef struct packed {
    logic [CNT_W-1:0]    f;
    logic [CNT_W-1:0]    l;
    logic [CNT_W-1:0]    d;
  } counts_t;

  // Append request broadcast to the cells.
  typedef struct packed {
    logic                en_f;
    logic                en_l;
    logic                en_d;
    logic [IDX_W-1:0]    idx;
    logic [ENTRY_W-1:0]  val;
  } wr_t;

  // Kind of a word before table and range checks.
  function automatic kind_t decode(input logic [15:0] op);
    kind_t k;
    k = K_DATA;
    if (op[15:4] == 12'h00c) begin
      k = K_SCD;
    end else if (op == 16'h00e0) begin
      k = K_CLS;
    end else if (op == 16'h00ee) begin
      k = K_RET;
    end else if (op == 16'h00fb) begin
      k = K_SCR;
    end else if (op == 16'h00fc) begin
      k = K_SCL;
    end else if (op == 16'h00fd) begin
      k = K_EXIT;
    end else if (op == 16'h00fe) begin
      k = K_LOW;
    end else if (op == 16'h00ff) begin
      k = K_HIGH;
    end else begin
      unique case (op[15:12])
        4'h1: k = K_JP;
        4'h2: k = K_CALL;
        4'h3: k = K_SE_KK;
        4'h4: k = K_SNE_KK;
        4'h5: k = (op[3:0] == 4'h0) ? K_SE_XY : K_DATA;
        4'h6: k = K_LD_KK;
        4'h7: k = K_ADD_KK;
        4'h8: begin
          unique case (op[3:0])
            4'h0: k = K_LD_XY;
            4'h1: k = K_OR;
            4'h2: k = K_AND;
            4'h3: k = K_XOR;
            4'h4: k = K_ADD_XY;
            4'h5: k = K_SUB;
            4'h6: k = K_SHR;
            4'h7: k = K_SUBN;
            4'he: k = K_SHL;
            default: k = K_DATA;
          endcase
        end
        4'h9: k = (op[3:0] == 4'h0) ? K_SNE_XY : K_DATA;
        4'ha: k = K_LD_I;
        4'hb: k = K_JP_V0;
        4'hc: k = K_RND;
        4'hd: k = K_DRW;
        4'he: begin
          if (op[7:0] == 8'h9e) k = K_SKP;
          else if (op[7:0] == 8'ha1) k = K_SKNP;
          else k = K_DATA;
        end
        4'hf: begin
          unique case (op[7:0])
            8'h07: k = K_LD_X_DT;
            8'h0a: k = K_LD_X_K;
            8'h15: k = K_LD_DT_X;
            8'h18: k = K_LD_ST_X;
            8'h1e: k = K_ADD_I_X;
            8'h29: k = K_LD_LF;
            8'h30: k = K_LD_HF;
            8'h33: k = K_LD_B;
            8'h55: k = K_LD_MEM_X;
            8'h65: k = K_LD_X_MEM;
            8'h75: k = K_LD_R_X;
            8'h85: k = K_LD_X_R;
            default: k = K_DATA;
          endcase
        end
        default: k = K_DATA;
      endcase
    end
    return k;
  endfunction

endpackage

// ===== design/soc_if.sv =====
interface soc_in_if;
  logic               valid;
  logic               ready;
  soc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface soc_out_if;
  logic               valid;
  logic               ready;
  soc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface soc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [soc_pkg::ADDR_W-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/soc_cell.sv =====
module soc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [soc_pkg::IDX_W-1:0]   cell_idx,
  input  soc_pkg::counts_t            counts,
  input  soc_pkg::wr_t                wr,
  input  soc_pkg::token_t             tok_in,
  output soc_pkg::token_t             tok_out
);

  logic [soc_pkg::ENTRY_W-1:0] f_r, l_r, d_r;
  soc_pkg::token_t             tok_r, tok_nxt;
  logic                        fact, lact, dact, tact;
  logic [soc_pkg::ENTRY_W-1:0] tent;
  logic                        here_lo;

  // An entry takes part only when it lies below its table's fill level.
  assign fact = {1'b0, cell_idx} < counts.f;
  assign lact = {1'b0, cell_idx} < counts.l;
  assign dact = {1'b0, cell_idx} < counts.d;
  // Table addresses are 12 bits, so an address with bit 12 set never matches.
  assign here_lo = ~tok_in.here[soc_pkg::ADDR_W-1];

  // Entry of the table the target is looked up in.
  always_comb begin
    unique case (tok_in.tsel)
      soc_pkg::TS_FUNC:  begin tent = f_r; tact = fact; end
      soc_pkg::TS_LABEL: begin tent = l_r; tact = lact; end
      soc_pkg::TS_DATA:  begin tent = d_r; tact = dact; end
      default:           begin tent = f_r; tact = 1'b0; end
    endcase
  end

  // Compare this cell's entries against the token and pass it on.
  always_comb begin
    tok_nxt = tok_in;
    if (here_lo && fact && !tok_in.fhit && f_r == tok_in.here[soc_pkg::ENTRY_W-1:0]) begin
      tok_nxt.fhit = 1'b1;
      tok_nxt.fidx = cell_idx;
    end
    if (here_lo && lact && !tok_in.lhit && l_r == tok_in.here[soc_pkg::ENTRY_W-1:0]) begin
      tok_nxt.lhit = 1'b1;
      tok_nxt.lidx = cell_idx;
    end
    if (here_lo && dact && d_r == tok_in.here[soc_pkg::ENTRY_W-1:0]) begin
      tok_nxt.dhit = 1'b1;
    end
    if (tact && !tok_in.thit && tent == tok_in.nnn) begin
      tok_nxt.thit = 1'b1;
      tok_nxt.tidx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // Appends land in the cell whose index equals the table's fill level.
  always_ff @(posedge clk) begin
    if (wr.idx == cell_idx) begin
      if (wr.en_f) f_r <= wr.val;
      if (wr.en_l) l_r <= wr.val;
      if (wr.en_d) d_r <= wr.val;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== design/schip_opcode_classifier_core.sv =====
// Classifies one CHIP-8/SCHIP instruction word per transfer. The three address
// tables (subroutines, jump labels, data addresses) live in a row of 64 cells,
// one entry of each table per cell; a query token walks the row one cell per
// cycle. The launch register is loaded at the input transfer itself; the token
// then passes the 64 cell stages and the result register. The next word is
// taken only once the result has been transferred, so the block does not take
// a new word before it is through with the last one.
// The ROM size register can be written at any time the block is idle and
// bounds which jump and call targets are recorded.
module schip_opcode_classifier_core (
  input  logic        clk,
  input  logic        rst_n,
  soc_in_if.sink      in_if,
  soc_out_if.source   out_if,
  soc_cfg_if.sink     cfg_if
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

  localparam int N = soc_pkg::TABLE_ENTRIES;

  state_t                        state_r;
  logic [soc_pkg::ADDR_W-1:0]    rom_r;
  logic [soc_pkg::ADDR_W-1:0]    off_r;
  soc_pkg::counts_t              cnt_r;
  soc_pkg::token_t               launch_r;
  soc_pkg::kind_t                kind_r;
  logic [15:0]                   op_r;
  soc_pkg::out_item_t            out_r;
  soc_pkg::token_t               chain [N+1];
  soc_pkg::token_t               fin;
  soc_pkg::wr_t                  wr;

  logic                          in_acc;
  logic [soc_pkg::ADDR_W-1:0]    off_use;
  logic [soc_pkg::ADDR_W:0]      size_cap;
  logic [soc_pkg::ENTRY_W-1:0]   nnn;
  logic                          in_range;
  soc_pkg::kind_t                kind_dec, kind_l;
  soc_pkg::tsel_t                tsel_l;
  logic [soc_pkg::CNT_W-1:0]     tcnt;
  logic                          tfull;
  logic [5:0]                    tnum;
  logic                          tovf;

  assign in_acc    = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = (state_r == S_OUT);
  assign out_if.data  = out_r;

  // Launch-side decode and range check.
  assign off_use  = in_if.data.first_word ? '0 : off_r;
  assign size_cap = ({1'b0, rom_r} > soc_pkg::ROM_CAP) ? soc_pkg::ROM_CAP : {1'b0, rom_r};
  assign nnn      = in_if.data.opcode_word[soc_pkg::ENTRY_W-1:0];
  assign in_range = ({1'b0, nnn} >= soc_pkg::LOAD_BASE) &&
                    ({2'b00, nnn} < ({1'b0, soc_pkg::LOAD_BASE} + size_cap));
  assign kind_dec = soc_pkg::decode(in_if.data.opcode_word);

  always_comb begin
    kind_l = kind_dec;
    tsel_l = soc_pkg::TS_NONE;
    if (kind_dec == soc_pkg::K_JP || kind_dec == soc_pkg::K_CALL) begin
      if (!in_range) begin
        kind_l = soc_pkg::K_DATA;
      end else begin
        tsel_l = (kind_dec == soc_pkg::K_JP) ? soc_pkg::TS_LABEL : soc_pkg::TS_FUNC;
      end
    end else if (kind_dec == soc_pkg::K_LD_I) begin
      tsel_l = soc_pkg::TS_DATA;
    end
  end

  // Row of cells.
  assign chain[0] = launch_r;
  for (genvar g = 0; g < N; g++) begin : g_cell
    soc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (soc_pkg::IDX_W'(g)),
      .counts   (cnt_r),
      .wr       (wr),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end
  assign fin = chain[N];

  // Append decision once the token leaves the row.
  always_comb begin
    unique case (fin.tsel)
      soc_pkg::TS_FUNC:  tcnt = cnt_r.f;
      soc_pkg::TS_LABEL: tcnt = cnt_r.l;
      soc_pkg::TS_DATA:  tcnt = cnt_r.d;
      default:           tcnt = cnt_r.f;
    endcase
    tfull = (tcnt >= soc_pkg::CNT_FULL);
    wr.idx  = tcnt[soc_pkg::IDX_W-1:0];
    wr.val  = fin.nnn;
    wr.en_f = 1'b0;
    wr.en_l = 1'b0;
    wr.en_d = 1'b0;
    if (fin.valid && !fin.dhit && !fin.thit && !tfull) begin
      wr.en_f = (fin.tsel == soc_pkg::TS_FUNC);
      wr.en_l = (fin.tsel == soc_pkg::TS_LABEL);
      wr.en_d = (fin.tsel == soc_pkg::TS_DATA);
    end
  end

  // Target number and overflow flag of the word leaving the row.
  always_comb begin
    tnum = 6'd0;
    tovf = 1'b0;
    if (!fin.dhit && fin.tsel != soc_pkg::TS_NONE) begin
      if (fin.thit) begin
        if (fin.tsel != soc_pkg::TS_DATA) tnum = 6'(fin.tidx);
      end else if (tfull) begin
        tovf = 1'b1;
      end else if (fin.tsel != soc_pkg::TS_DATA) begin
        tnum = 6'(tcnt[soc_pkg::IDX_W-1:0]);
      end
    end
  end

  // Sequencer, counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rom_r    <= 13'(soc_pkg::MAX_ROM_BYTES);
      off_r    <= '0;
      cnt_r    <= '0;
      launch_r <= '0;
      kind_r   <= soc_pkg::K_DATA;
      op_r     <= '0;
      out_r    <= '0;
    end else begin
      if (cfg_if.valid) rom_r <= cfg_if.data;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_if.data.first_word) cnt_r <= '0;
            off_r    <= off_use + 13'd2;
            op_r     <= in_if.data.opcode_word;
            kind_r   <= kind_l;
            launch_r <= '{valid: 1'b1, here: soc_pkg::LOAD_BASE + off_use, nnn: nnn,
                          tsel: tsel_l, fhit: 1'b0, fidx: '0, lhit: 1'b0, lidx: '0,
                          dhit: 1'b0, thit: 1'b0, tidx: '0};
            state_r  <= S_RUN;
          end else begin
            launch_r.valid <= 1'b0;
          end
        end
        S_RUN: begin
          launch_r.valid <= 1'b0;
          if (fin.valid) begin
            if (wr.en_f) cnt_r.f <= cnt_r.f + 1'b1;
            if (wr.en_l) cnt_r.l <= cnt_r.l + 1'b1;
            if (wr.en_d) cnt_r.d <= cnt_r.d + 1'b1;
            out_r.word_address   <= fin.here;
            out_r.opcode_echo    <= op_r;
            out_r.func_hit       <= fin.fhit;
            out_r.func_number    <= fin.fhit ? 6'(fin.fidx) : 6'd0;
            out_r.label_hit      <= fin.lhit;
            out_r.label_number   <= fin.lhit ? 6'(fin.lidx) : 6'd0;
            out_r.target_number  <= tnum;
            out_r.table_overflow <= tovf;
            out_r.instr_kind     <= fin.dhit ? 6'(soc_pkg::K_DATA) : 6'(kind_r);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          launch_r.valid <= 1'b0;
          if (out_if.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_schip_opcode_classifier_core.sv =====
`timescale 1ns / 1ps

module tb_schip_opcode_classifier_core;
  import soc_pkg::*;

  logic clk;
  logic rst_n;

  soc_in_if  in_ch();
  soc_out_if out_ch();
  soc_cfg_if cfg_ch();

  schip_opcode_classifier_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  localparam int WATCHDOG_CYCLES = 20000;

  // Predictor state: offset, three address tables and their fill levels.
  logic [12:0] rom_size;
  logic [12:0] offs;
  logic [11:0] func_tab [TABLE_ENTRIES];
  logic [11:0] label_tab [TABLE_ENTRIES];
  logic [11:0] data_tab [TABLE_ENTRIES];
  int          func_cnt, label_cnt, data_cnt;

  out_item_t   pending_words [$];
  int          errors;
  int          words_sent, words_checked, overflows_seen, data_hits_seen;
  int          idle_cnt;
  bit          no_idle;
  bit          timed_out;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Returns the index of key among the first cnt entries, or -1.
  function automatic int find_addr(ref logic [11:0] tab [TABLE_ENTRIES], input int cnt,
                                   input logic [12:0] key);
    for (int k = 0; k < cnt; k++) begin
      if ({1'b0, tab[k]} == key) return k;
    end
    return -1;
  endfunction

  // Looks a target up, appends it when missing; -1 when the table is full.
  function automatic int find_or_append(ref logic [11:0] tab [TABLE_ENTRIES], ref int cnt,
                                        input logic [11:0] key);
    int j;
    j = find_addr(tab, cnt, {1'b0, key});
    if (j >= 0) return j;
    if (cnt >= TABLE_ENTRIES) return -1;
    tab[cnt] = key;
    cnt++;
    return cnt - 1;
  endfunction

  // Independent instruction decode, before table and range checks.
  function automatic kind_t decode_word(input logic [15:0] op);
    logic [3:0] lo4;
    logic [7:0] lo8;
    lo4 = op[3:0];
    lo8 = op[7:0];
    if (op[15:4] == 12'h00c) return K_SCD;
    if (op == 16'h00e0) return K_CLS;
    if (op == 16'h00ee) return K_RET;
    if (op >= 16'h00fb && op <= 16'h00ff) return kind_t'(int'(K_SCR) + int'(op - 16'h00fb));
    case (op[15:12])
      4'h0: return K_DATA;
      4'h1: return K_JP;
      4'h2: return K_CALL;
      4'h3: return K_SE_KK;
      4'h4: return K_SNE_KK;
      4'h5: return (lo4 == 0) ? K_SE_XY : K_DATA;
      4'h6: return K_LD_KK;
      4'h7: return K_ADD_KK;
      4'h8: begin
        if (lo4 <= 7) return kind_t'(int'(K_LD_XY) + lo4);
        if (lo4 == 4'he) return K_SHL;
        return K_DATA;
      end
      4'h9: return (lo4 == 0) ? K_SNE_XY : K_DATA;
      4'ha: return K_LD_I;
      4'hb: return K_JP_V0;
      4'hc: return K_RND;
      4'hd: return K_DRW;
      4'he: begin
        if (lo8 == 8'h9e) return K_SKP;
        if (lo8 == 8'ha1) return K_SKNP;
        return K_DATA;
      end
      default: begin
        case (lo8)
          8'h07: return K_LD_X_DT;
          8'h0a: return K_LD_X_K;
          8'h15: return K_LD_DT_X;
          8'h18: return K_LD_ST_X;
          8'h1e: return K_ADD_I_X;
          8'h29: return K_LD_LF;
          8'h30: return K_LD_HF;
          8'h33: return K_LD_B;
          8'h55: return K_LD_MEM_X;
          8'h65: return K_LD_X_MEM;
          8'h75: return K_LD_R_X;
          8'h85: return K_LD_X_R;
          default: return K_DATA;
        endcase
      end
    endcase
  endfunction

  // Computes the classification of one word and advances the state.
  function automatic out_item_t classify_word(input in_item_t it);
    out_item_t r;
    logic [12:0] here;
    logic [11:0] nnn;
    int          lim, fj, lj, j;
    kind_t       kind;
    if (it.first_word) begin
      offs = '0;
      func_cnt = 0;
      label_cnt = 0;
      data_cnt = 0;
    end
    here = LOAD_BASE + offs;
    nnn  = it.opcode_word[11:0];
    lim  = (rom_size > MAX_ROM_BYTES) ? MAX_ROM_BYTES : int'(rom_size);
    fj   = find_addr(func_tab, func_cnt, here);
    lj   = find_addr(label_tab, label_cnt, here);
    r    = '0;
    if (find_addr(data_tab, data_cnt, here) >= 0) begin
      kind = K_DATA;
      data_hits_seen++;
    end else begin
      kind = decode_word(it.opcode_word);
      if (kind == K_JP || kind == K_CALL) begin
        if (nnn < 12'h200 || int'(nnn) >= 512 + lim) begin
          kind = K_DATA;
        end else begin
          if (kind == K_JP) j = find_or_append(label_tab, label_cnt, nnn);
          else j = find_or_append(func_tab, func_cnt, nnn);
          if (j < 0) r.table_overflow = 1'b1;
          else r.target_number = 6'(j);
        end
      end else if (kind == K_LD_I) begin
        if (find_or_append(data_tab, data_cnt, nnn) < 0) r.table_overflow = 1'b1;
      end
    end
    r.word_address = here;
    r.opcode_echo  = it.opcode_word;
    r.instr_kind   = kind;
    r.func_hit     = (fj >= 0);
    r.func_number  = (fj >= 0) ? 6'(fj) : 6'd0;
    r.label_hit    = (lj >= 0);
    r.label_number = (lj >= 0) ? 6'(lj) : 6'd0;
    offs = offs + 13'd2;
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 38);
  endfunction

  // Result side: random stalls, field-by-field compare against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected result at address", got.word_address, -1);
        end else begin
          want = pending_words.pop_front();
          words_checked++;
          if (got.word_address != want.word_address)
            report_mismatch("word_address", got.word_address, want.word_address);
          if (got.opcode_echo != want.opcode_echo)
            report_mismatch("opcode_echo", got.opcode_echo, want.opcode_echo);
          if (got.instr_kind != want.instr_kind)
            report_mismatch("instr_kind", got.instr_kind, want.instr_kind);
          if (got.func_hit != want.func_hit)
            report_mismatch("func_hit", got.func_hit, want.func_hit);
          if (got.func_number != want.func_number)
            report_mismatch("func_number", got.func_number, want.func_number);
          if (got.label_hit != want.label_hit)
            report_mismatch("label_hit", got.label_hit, want.label_hit);
          if (got.label_number != want.label_number)
            report_mismatch("label_number", got.label_number, want.label_number);
          if (got.target_number != want.target_number)
            report_mismatch("target_number", got.target_number, want.target_number);
          if (got.table_overflow != want.table_overflow)
            report_mismatch("table_overflow", got.table_overflow, want.table_overflow);
          if (want.table_overflow) overflows_seen++;
        end
      end
      out_ch.ready <= !idle_now();
    end
  end

  // Watchdog on cycles without an input or configuration transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cnt >= WATCHDOG_CYCLES && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired with %0d results outstanding", pending_words.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Writes the ROM size register while the block is idle.
  task automatic write_rom_size(input logic [12:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    rom_size = val;
    cfg_ch.valid <= 1'b0;
  endtask

  // Sends one word, with a random gap before it.
  task automatic send_word(input bit first, input logic [15:0] op);
    in_item_t it;
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    it.first_word  = first;
    it.opcode_word = op;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    pending_words = {pending_words, classify_word(it)};
    words_sent++;
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Random word, biased toward jumps, calls and I loads with targets in the ROM.
  function automatic logic [15:0] random_word(input int rom_words);
    logic [11:0] tgt;
    int sel;
    sel = $urandom_range(99);
    tgt = 12'h200 + 12'(2 * $urandom_range(rom_words + 2));
    if (sel < 20) return {4'h1, tgt};
    if (sel < 35) return {4'h2, tgt};
    if (sel < 50) return {4'ha, tgt};
    if (sel < 55) return {4'h1 + 4'($urandom_range(1)), 12'($urandom)};
    return 16'($urandom);
  endfunction

  // Directed stimulus: first word flag, opcode, expected kind.
  typedef struct {
    bit          first;
    logic [15:0] op;
    kind_t       kind;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{1'b1, 16'h00c5, K_SCD},    '{1'b0, 16'h00e0, K_CLS},   '{1'b0, 16'h00ee, K_RET},
    '{1'b0, 16'h00fb, K_SCR},    '{1'b0, 16'h00ff, K_HIGH},  '{1'b0, 16'h0123, K_DATA},
    '{1'b0, 16'h120c, K_JP},     '{1'b0, 16'h220e, K_CALL},  '{1'b0, 16'h5ab0, K_SE_XY},
    '{1'b0, 16'h5ab1, K_DATA},   '{1'b0, 16'h8abe, K_SHL},   '{1'b0, 16'h8ab9, K_DATA},
    '{1'b0, 16'h9ab0, K_SNE_XY}, '{1'b0, 16'ha21a, K_LD_I},  '{1'b0, 16'he19e, K_SKP},
    '{1'b0, 16'he1a1, K_SKNP},   '{1'b0, 16'hf285, K_LD_X_R}, '{1'b0, 16'hf2ff, K_DATA},
    '{1'b0, 16'h1000, K_DATA},   '{1'b0, 16'h2fff, K_CALL},  '{1'b0, 16'h1210, K_JP},
    '{1'b0, 16'hffff, K_DATA},   '{1'b0, 16'hb000, K_JP_V0}
  };

  initial begin
    out_item_t want;
    logic [12:0] sizes [6] = '{13'd4096, 13'd0, 13'd1, 13'h1fff, 13'd64, 13'd600};
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    overflows_seen = 0;
    data_hits_seen = 0;
    no_idle = 1'b0;
    timed_out = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rom_size = 13'd4096;
    offs = '0;
    func_cnt = 0;
    label_cnt = 0;
    data_cnt = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with the kind typed in per row.
    write_rom_size(13'd4096);
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].first, dir_rows[i].op);
      want = pending_words[$];
      if (want.instr_kind != dir_rows[i].kind)
        report_mismatch("table kind", want.instr_kind, dir_rows[i].kind);
    end
    drain_results();

    // Random phases over several ROM sizes; each starts a fresh program.
    for (int ph = 0; ph < 6; ph++) begin
      write_rom_size(sizes[ph]);
      no_idle = (ph == 2);
      for (int k = 0; k < 135; k++) begin
        send_word(k == 0 || $urandom_range(199) == 0,
                  random_word(ph == 4 ? 40 : (ph == 5 ? 300 : 120)));
        // Hold off once per phase, at word 60, until all results are in.
        if (k == 60) while (pending_words.size() != 0) @(posedge clk);
      end
      drain_results();
    end

    // Overflow stress: many distinct targets in one program, so tables fill.
    write_rom_size(13'd4096);
    for (int k = 0; k < 220; k++) begin
      send_word(k == 0, {(k % 3 == 0) ? 4'h1 : ((k % 3 == 1) ? 4'h2 : 4'ha),
                         12'h300 + 12'(k * 2)});
    end
    // Let the last results come in.
    drain_results();

    $display("Sent %0d words, checked %0d results, %0d table overflows, %0d data hits",
             words_sent, words_checked, overflows_seen, data_hits_seen);
    $display("ROM sizes covered: 0, 1, 64, 600, 4096 and above the cap");
    if (errors == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
